// File: rtl/sum_checked_packet_deframer_macros.svh
// Assertion helpers used by the deframer parser RTL.
`ifndef SUM_CHECKED_PACKET_DEFRAMER_MACROS_SVH
`define SUM_CHECKED_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

// File: rtl/scpd_pkg.sv
`timescale 1ns / 1ps

package scpd_pkg;

  localparam logic [7:0] SYNC_FIRST    = 8'hEF;
  localparam logic [7:0] SYNC_SECOND   = 8'h01;
  localparam logic [7:0] TYPE_CONTINUE = 8'h02;

  localparam logic [31:0] ADDR_RESET = 32'hFFFF_FFFF;
  localparam logic [15:0] MAX_RESET  = 16'd512;

  localparam logic [0:0] REG_MODULE_ADDR = 1'd0;
  localparam logic [0:0] REG_MAX_LEN     = 1'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CKSUM   = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_BAD_LEN = 2'd3;

  typedef enum logic [3:0] {
    PH_HUNT     = 4'd0,
    PH_SYNC2    = 4'd1,
    PH_ADDR     = 4'd2,
    PH_ADDR_BAD = 4'd3,
    PH_TYPE     = 4'd4,
    PH_LEN_HI   = 4'd5,
    PH_LEN_LO   = 4'd6,
    PH_PAYLOAD  = 4'd7,
    PH_CK_HI    = 4'd8,
    PH_CK_LO    = 4'd9
  } phase_t;

  typedef struct packed {
    logic        is_data;
    logic [7:0]  data_byte;
    logic [15:0] byte_offset;
    logic [7:0]  packet_type;
    logic [1:0]  status;
    logic        message_end;
  } res_t;

endpackage

// File: rtl/scpd_in_stage.sv
`timescale 1ns / 1ps

module scpd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_q
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       take;

  assign in_tready  = !valid_r || advance;
  assign take       = in_tvalid && in_tready;
  assign byte_valid = valid_r;
  assign byte_q     = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_tdata;
    end
  end

endmodule

// File: rtl/scpd_parser.sv
`timescale 1ns / 1ps
`include "sum_checked_packet_deframer_macros.svh"

module scpd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [0:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                step,
  input  logic [7:0]          b,
  output logic                res_valid,
  output scpd_pkg::res_t      res
);

  logic [31:0]      addr_r;
  logic [15:0]      max_r;
  scpd_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]       hcount_r, hcount_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [15:0]      remain_r, remain_nxt;
  logic [15:0]      total_r, total_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       ckhi_r, ckhi_nxt;

  logic [7:0]  expect_byte;
  logic        addr_bad;
  logic [15:0] len;
  logic [15:0] len2;
  logic [16:0] new_total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= scpd_pkg::ADDR_RESET;
      max_r  <= scpd_pkg::MAX_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        scpd_pkg::REG_MODULE_ADDR: addr_r <= cfg_data;
        scpd_pkg::REG_MAX_LEN:     max_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (hcount_r)
      2'd0:    expect_byte = addr_r[31:24];
      2'd1:    expect_byte = addr_r[23:16];
      2'd2:    expect_byte = addr_r[15:8];
      default: expect_byte = addr_r[7:0];
    endcase
  end

  assign addr_bad  = (phase_r == scpd_pkg::PH_ADDR_BAD) || (b != expect_byte);
  assign len       = {remain_r[15:8], b};
  assign len2      = len - 16'd2;
  assign new_total = {1'b0, total_r} + {1'b0, len2};

  always_comb begin
    phase_nxt  = phase_r;
    hcount_nxt = hcount_r;
    type_nxt   = type_r;
    remain_nxt = remain_r;
    total_nxt  = total_r;
    sum_nxt    = sum_r;
    ckhi_nxt   = ckhi_r;
    res_valid  = 1'b0;
    res             = '0;
    res.byte_offset = total_r;
    res.packet_type = type_r;
    if (step) begin
      unique case (phase_r)
        scpd_pkg::PH_HUNT: begin
          if (b == scpd_pkg::SYNC_FIRST) begin
            phase_nxt = scpd_pkg::PH_SYNC2;
          end
        end
        scpd_pkg::PH_SYNC2: begin
          phase_nxt  = (b == scpd_pkg::SYNC_SECOND) ? scpd_pkg::PH_ADDR : scpd_pkg::PH_HUNT;
          hcount_nxt = 2'd0;
        end
        scpd_pkg::PH_ADDR, scpd_pkg::PH_ADDR_BAD: begin
          if (hcount_r == 2'd3) begin
            phase_nxt  = addr_bad ? scpd_pkg::PH_HUNT : scpd_pkg::PH_TYPE;
            hcount_nxt = 2'd0;
          end else begin
            phase_nxt  = addr_bad ? scpd_pkg::PH_ADDR_BAD : scpd_pkg::PH_ADDR;
            hcount_nxt = hcount_r + 2'd1;
          end
        end
        scpd_pkg::PH_TYPE: begin
          type_nxt  = b;
          sum_nxt   = {8'h00, b};
          phase_nxt = scpd_pkg::PH_LEN_HI;
        end
        scpd_pkg::PH_LEN_HI: begin
          remain_nxt = {b, 8'h00};
          sum_nxt    = sum_r + {8'h00, b};
          phase_nxt  = scpd_pkg::PH_LEN_LO;
        end
        scpd_pkg::PH_LEN_LO: begin
          sum_nxt = sum_r + {8'h00, b};
          if (len < 16'd2) begin
            res_valid       = 1'b1;
            res.status      = scpd_pkg::ST_BAD_LEN;
            res.message_end = 1'b1;
            total_nxt       = '0;
            remain_nxt      = '0;
            phase_nxt       = scpd_pkg::PH_HUNT;
          end else if (new_total > {1'b0, max_r}) begin
            res_valid       = 1'b1;
            res.status      = scpd_pkg::ST_TOO_LONG;
            res.message_end = 1'b1;
            total_nxt       = '0;
            remain_nxt      = '0;
            phase_nxt       = scpd_pkg::PH_HUNT;
          end else begin
            remain_nxt = len2;
            phase_nxt  = (len2 == 16'd0) ? scpd_pkg::PH_CK_HI : scpd_pkg::PH_PAYLOAD;
          end
        end
        scpd_pkg::PH_PAYLOAD: begin
          res_valid     = 1'b1;
          res.is_data   = 1'b1;
          res.data_byte = b;
          sum_nxt       = sum_r + {8'h00, b};
          total_nxt     = total_r + 16'd1;
          remain_nxt    = remain_r - 16'd1;
          if (remain_r == 16'd1) begin
            phase_nxt = scpd_pkg::PH_CK_HI;
          end
        end
        scpd_pkg::PH_CK_HI: begin
          ckhi_nxt  = b;
          phase_nxt = scpd_pkg::PH_CK_LO;
        end
        scpd_pkg::PH_CK_LO: begin
          phase_nxt = scpd_pkg::PH_HUNT;
          res_valid = 1'b1;
          if ({ckhi_r, b} != sum_r) begin
            res.status      = scpd_pkg::ST_CKSUM;
            res.message_end = 1'b1;
            total_nxt       = '0;
          end else if (type_r != scpd_pkg::TYPE_CONTINUE) begin
            res.status      = scpd_pkg::ST_OK;
            res.message_end = 1'b1;
            total_nxt       = '0;
          end else begin
            res.status = scpd_pkg::ST_OK;
          end
        end
        default: begin
          phase_nxt = scpd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= scpd_pkg::PH_HUNT;
      hcount_r <= '0;
      type_r   <= '0;
      remain_r <= '0;
      total_r  <= '0;
      sum_r    <= '0;
      ckhi_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      hcount_r <= hcount_nxt;
      type_r   <= type_nxt;
      remain_r <= remain_nxt;
      total_r  <= total_nxt;
      sum_r    <= sum_nxt;
      ckhi_r   <= ckhi_nxt;
    end
  end

  `SCPD_ASSERT_IMP(a_payload_pending, clk, rst_n, phase_r == scpd_pkg::PH_PAYLOAD, remain_r != 16'd0)
  `SCPD_ASSERT_NXT(a_ck_lo_rehunt, clk, rst_n, step && phase_r == scpd_pkg::PH_CK_LO, phase_r == scpd_pkg::PH_HUNT)
  `SCPD_ASSERT_NXT(a_end_clears_total, clk, rst_n, step && res_valid && res.message_end, total_r == 16'd0)
  `SCPD_ASSERT_NXT(a_data_counts_up, clk, rst_n, step && res_valid && res.is_data, total_r == $past(total_r) + 16'd1)

endmodule

// File: rtl/scpd_out_stage.sv
`timescale 1ns / 1ps

module scpd_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  input  scpd_pkg::res_t res,
  output logic           advance,
  output logic           out_valid,
  input  logic           out_ready,
  output scpd_pkg::res_t out_res
);

  logic           valid_r;
  scpd_pkg::res_t res_r;

  assign advance   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// File: rtl/sum_checked_packet_deframer.sv
`timescale 1ns / 1ps

// Serial packet deframer: takes one received byte per request on in_, hunts
// for the EF 01 sync pair, checks the four-byte module address, reads type and
// length, and delivers each payload byte with its message offset, then one
// status request per packet after its 16-bit additive checksum (or at once on
// a bad or over-long length). Type 0x02 packets continue the message. One byte
// is taken every clock while the output is not stalled; each byte's result
// passes through the input register, the parser step and the output register.
// Configuration writes (index 0 module address, index 1 maximum message
// length) are always ready and take effect on the next cycle; there is no
// clearing pass after reset.
module sum_checked_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] data_byte, [23:8] byte_offset,
                                  // [31:24] packet_type, [33:32] status, zero pad
  output logic        out_tuser,  // [0] is_data
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic           advance;
  logic           byte_valid;
  logic [7:0]     byte_q;
  logic           step;
  logic           res_valid;
  scpd_pkg::res_t res;
  scpd_pkg::res_t out_res;

  assign cfg_ready = 1'b1;
  assign step      = byte_valid && advance;

  scpd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  scpd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .b         (byte_q),
    .res_valid (res_valid),
    .res       (res)
  );

  scpd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {6'b000000, out_res.status, out_res.packet_type,
                      out_res.byte_offset, out_res.data_byte};
  assign out_tuser = out_res.is_data;
  assign out_tlast = out_res.message_end;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT = 600000;
  localparam int DRAIN = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;    // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;           // [7:0] data_byte, [23:8] byte_offset,
                                    // [31:24] packet_type, [33:32] status, zero pad
  logic        out_tuser;           // [0] is_data
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = scpd_pkg::REG_MODULE_ADDR;
  logic [31:0] cfg_data = 32'h0;

  sum_checked_packet_deframer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // deframer state mirror
  logic [31:0]      m_addr;
  logic [15:0]      m_max;
  scpd_pkg::phase_t ph;
  logic [1:0]       hdr_cnt;
  logic [7:0]       cur_type;
  logic [15:0]      remaining;
  logic [15:0]      msg_total;
  logic [15:0]      run_sum;
  logic [7:0]       ck_hi;

  scpd_pkg::res_t   pending_q[$];

  int unsigned cycles;
  int unsigned errors;
  int unsigned bytes_fed;
  int unsigned reg_writes;
  int unsigned payload_seen;
  int unsigned status_seen[4];
  int          hold_left;
  int          stall_left;
  bit          idle_on = 1'b1;

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_status(logic [1:0] st, logic fin);
    scpd_pkg::res_t r;
    r.is_data     = 1'b0;
    r.data_byte   = 8'h00;
    r.byte_offset = msg_total;
    r.packet_type = cur_type;
    r.status      = st;
    r.message_end = fin;
    pending_q.push_back(r);
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [15:0]    len;
    logic [7:0]     addr_byte;
    scpd_pkg::res_t r;
    case (ph)
      scpd_pkg::PH_HUNT: begin
        if (b == scpd_pkg::SYNC_FIRST) ph = scpd_pkg::PH_SYNC2;
      end
      scpd_pkg::PH_SYNC2: begin
        ph = (b == scpd_pkg::SYNC_SECOND) ? scpd_pkg::PH_ADDR : scpd_pkg::PH_HUNT;
        hdr_cnt = 2'd0;
      end
      scpd_pkg::PH_ADDR, scpd_pkg::PH_ADDR_BAD: begin
        addr_byte = 8'(m_addr >> (8 * (3 - int'(hdr_cnt))));
        if (b != addr_byte) ph = scpd_pkg::PH_ADDR_BAD;
        if (hdr_cnt == 2'd3) begin
          ph = (ph == scpd_pkg::PH_ADDR) ? scpd_pkg::PH_TYPE : scpd_pkg::PH_HUNT;
          hdr_cnt = 2'd0;
        end else begin
          hdr_cnt = hdr_cnt + 2'd1;
        end
      end
      scpd_pkg::PH_TYPE: begin
        cur_type = b;
        run_sum = {8'h00, b};
        ph = scpd_pkg::PH_LEN_HI;
      end
      scpd_pkg::PH_LEN_HI: begin
        remaining = {b, 8'h00};
        run_sum = run_sum + b;
        ph = scpd_pkg::PH_LEN_LO;
      end
      scpd_pkg::PH_LEN_LO: begin
        len = {remaining[15:8], b};
        run_sum = run_sum + b;
        if (len < 16'd2) begin
          push_status(scpd_pkg::ST_BAD_LEN, 1'b1);
          msg_total = 16'd0;
          remaining = 16'd0;
          ph = scpd_pkg::PH_HUNT;
        end else if (int'(msg_total) + int'(len) - 2 > int'(m_max)) begin
          push_status(scpd_pkg::ST_TOO_LONG, 1'b1);
          msg_total = 16'd0;
          remaining = 16'd0;
          ph = scpd_pkg::PH_HUNT;
        end else begin
          remaining = len - 16'd2;
          ph = (len == 16'd2) ? scpd_pkg::PH_CK_HI : scpd_pkg::PH_PAYLOAD;
        end
      end
      scpd_pkg::PH_PAYLOAD: begin
        r.is_data     = 1'b1;
        r.data_byte   = b;
        r.byte_offset = msg_total;
        r.packet_type = cur_type;
        r.status      = scpd_pkg::ST_OK;
        r.message_end = 1'b0;
        pending_q.push_back(r);
        run_sum = run_sum + b;
        msg_total = msg_total + 16'd1;
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) ph = scpd_pkg::PH_CK_HI;
      end
      scpd_pkg::PH_CK_HI: begin
        ck_hi = b;
        ph = scpd_pkg::PH_CK_LO;
      end
      scpd_pkg::PH_CK_LO: begin
        ph = scpd_pkg::PH_HUNT;
        if ({ck_hi, b} != run_sum) begin
          push_status(scpd_pkg::ST_CKSUM, 1'b1);
          msg_total = 16'd0;
        end else if (cur_type != scpd_pkg::TYPE_CONTINUE) begin
          push_status(scpd_pkg::ST_OK, 1'b1);
          msg_total = 16'd0;
        end else begin
          push_status(scpd_pkg::ST_OK, 1'b0);
        end
      end
      default: ph = scpd_pkg::PH_HUNT;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    bytes_fed++;
    deframe_byte(b);
  endtask

  // send one packet; the body follows only when the header will be taken
  task automatic send_frame(input logic [31:0] addr, input logic [7:0] ptype,
                            input logic [15:0] len_field, input bit bad_sum);
    logic [15:0] sum;
    logic [7:0]  b;
    bit          body;
    body = (addr == m_addr) && (len_field >= 16'd2) &&
           (int'(msg_total) + int'(len_field) - 2 <= int'(m_max));
    send_byte(scpd_pkg::SYNC_FIRST);
    send_byte(scpd_pkg::SYNC_SECOND);
    for (int i = 3; i >= 0; i--) send_byte(addr[8*i +: 8]);
    send_byte(ptype);
    send_byte(len_field[15:8]);
    send_byte(len_field[7:0]);
    if (body) begin
      sum = 16'(ptype) + len_field[15:8] + len_field[7:0];
      for (int i = 0; i < int'(len_field) - 2; i++) begin
        b = pick_byte();
        sum = sum + b;
        send_byte(b);
      end
      if (bad_sum) sum = sum ^ (16'd1 << $urandom_range(0, 15));
      send_byte(sum[15:8]);
      send_byte(sum[7:0]);
    end
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == scpd_pkg::REG_MODULE_ADDR) m_addr = val;
    else m_max = val[15:0];
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop valid, let every pending result drain, then cover bytes still in flight
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      if (stall_left == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    scpd_pkg::res_t got;
    scpd_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.is_data     = out_tuser;
      got.data_byte   = out_tdata[7:0];
      got.byte_offset = out_tdata[23:8];
      got.packet_type = out_tdata[31:24];
      got.status      = out_tdata[33:32];
      got.message_end = out_tlast;
      if (got.is_data) payload_seen++;
      else status_seen[got.status]++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: data=%0b byte=%h off=%0d type=%h st=%0d end=%0b",
                   got.is_data, got.data_byte, got.byte_offset, got.packet_type,
                   got.status, got.message_end);
      end else begin
        want = pending_q.pop_front();
        if (got !== want || out_tdata[39:34] !== 6'd0) begin
          errors++;
          if (errors <= 10) begin
            $display("want: data=%0b byte=%h off=%0d type=%h st=%0d end=%0b",
                     want.is_data, want.data_byte, want.byte_offset, want.packet_type,
                     want.status, want.message_end);
            $display("got:  data=%0b byte=%h off=%0d type=%h st=%0d end=%0b pad=%h",
                     got.is_data, got.data_byte, got.byte_offset, got.packet_type,
                     got.status, got.message_end, out_tdata[39:34]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_q.size());
      $display("sum_checked_packet_deframer: mismatch");
      $finish;
    end
  end

  task automatic test_clean_frames();
    send_frame(m_addr, 8'h01, 16'd2, 1'b0);
    send_frame(m_addr, 8'hFF, 16'd6, 1'b0);
    send_frame(m_addr, 8'h00, 16'd3, 1'b0);
  endtask

  task automatic test_sync_and_address();
    send_byte(scpd_pkg::SYNC_FIRST);
    send_byte(8'h00);
    send_byte(scpd_pkg::SYNC_FIRST);
    send_byte(scpd_pkg::SYNC_FIRST);
    send_byte(scpd_pkg::SYNC_SECOND);
    send_frame(m_addr ^ 32'h0000_0100, 8'h01, 16'd4, 1'b0);
    send_frame(m_addr ^ 32'h8000_0000, 8'h01, 16'd4, 1'b0);
    send_frame(m_addr, 8'h07, 16'd3, 1'b0);
  endtask

  task automatic test_length_faults();
    send_frame(m_addr, 8'h03, 16'd0, 1'b0);
    send_frame(m_addr, 8'h03, 16'd1, 1'b0);
    send_frame(m_addr, 8'h03, 16'hFFFF, 1'b0);
    send_frame(m_addr, 8'h03, 16'd5, 1'b1);
  endtask

  task automatic test_message_chain();
    send_frame(m_addr, scpd_pkg::TYPE_CONTINUE, 16'd5, 1'b0);
    send_frame(m_addr, scpd_pkg::TYPE_CONTINUE, 16'd4, 1'b0);
    send_frame(m_addr, 8'h03, 16'd3, 1'b0);
    send_frame(m_addr, scpd_pkg::TYPE_CONTINUE, 16'd4, 1'b0);
    send_frame(m_addr, scpd_pkg::TYPE_CONTINUE, 16'd5, 1'b1);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_reg(scpd_pkg::REG_MODULE_ADDR, 32'h0000_0000);
    write_reg(scpd_pkg::REG_MAX_LEN, 32'd0);
    send_frame(m_addr, 8'h10, 16'd2, 1'b0);
    send_frame(m_addr, scpd_pkg::TYPE_CONTINUE, 16'd2, 1'b0);
    send_frame(m_addr, 8'h10, 16'd3, 1'b0);
    wait_idle();
    write_reg(scpd_pkg::REG_MODULE_ADDR, 32'hEF01_EF01);
    write_reg(scpd_pkg::REG_MAX_LEN, 32'd65535);
    send_frame(m_addr, scpd_pkg::TYPE_CONTINUE, 16'd5, 1'b0);
    send_frame(m_addr, 8'h20, 16'hFFFF, 1'b0);
    send_frame(m_addr, 8'h21, 16'd4, 1'b0);
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_reg(scpd_pkg::REG_MODULE_ADDR, 32'h1234_5678);
    write_reg(scpd_pkg::REG_MAX_LEN, 32'd1000);
    idle_on = 1'b0;
    hold_left = 200;
    send_frame(m_addr, 8'h05, 16'd122, 1'b0);
    wait_idle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    int          r;
    int          room;
    int          n;
    logic [7:0]  ptype;
    logic [31:0] addr_val;
    logic [15:0] max_val;
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      r = $urandom_range(0, 3);
      addr_val = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF :
                 (r == 2) ? 32'hEF01_EF01 : $urandom();
      r = $urandom_range(0, 9);
      max_val = (r == 0) ? 16'd0 : (r == 1) ? 16'd65535 :
                (r < 5) ? 16'($urandom_range(1, 40)) : 16'($urandom_range(40, 700));
      write_reg(scpd_pkg::REG_MODULE_ADDR, addr_val);
      write_reg(scpd_pkg::REG_MAX_LEN, {16'h0, max_val});
      idle_on = (p != 3);
      stop_at = bytes_fed + 110;
      while (bytes_fed < stop_at) begin
        r = $urandom_range(0, 99);
        room = int'(m_max) - int'(msg_total);
        if (room <= 0) n = 0;
        else if ($urandom_range(0, 9) == 0) n = $urandom_range(0, (room < 80) ? room : 80);
        else n = $urandom_range(0, (room < 8) ? room : 8);
        ptype = ($urandom_range(0, 9) < 4) ? scpd_pkg::TYPE_CONTINUE :
                8'($urandom_range(0, 255));
        if (r < 50) begin
          send_frame(m_addr, ptype, 16'(n + 2), 1'b0);
        end else if (r < 58) begin
          send_frame(m_addr, ptype, 16'(n + 2), 1'b1);
        end else if (r < 64) begin
          send_frame(m_addr, ptype, 16'($urandom_range(0, 1)), 1'b0);
        end else if (r < 70) begin
          n = room + 1 + $urandom_range(0, 20);
          send_frame(m_addr, ptype, (n > 65533) ? 16'd2 : 16'(n + 2), 1'b0);
        end else if (r < 78) begin
          send_frame(m_addr ^ (32'd1 << $urandom_range(0, 31)), ptype, 16'(n + 2), 1'b0);
        end else if (r < 86) begin
          send_byte(scpd_pkg::SYNC_FIRST);
          do r = $urandom_range(0, 255);
          while (8'(r) == scpd_pkg::SYNC_SECOND || 8'(r) == scpd_pkg::SYNC_FIRST);
          send_byte(8'(r));
        end else begin
          repeat ($urandom_range(1, 6)) begin
            do r = $urandom_range(0, 255); while (8'(r) == scpd_pkg::SYNC_FIRST);
            send_byte(8'(r));
          end
        end
        if ($urandom_range(0, 39) == 0) wait_idle();
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    m_addr = scpd_pkg::ADDR_RESET;
    m_max = scpd_pkg::MAX_RESET;
    ph = scpd_pkg::PH_HUNT;
    hdr_cnt = 2'd0;
    cur_type = 8'h00;
    remaining = 16'd0;
    msg_total = 16'd0;
    run_sum = 16'd0;
    ck_hi = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_clean_frames();
    test_sync_and_address();
    test_length_faults();
    test_message_chain();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    $display("fed %0d bytes, %0d register writes; checked %0d payload bytes",
             bytes_fed, reg_writes, payload_seen);
    $display("status results: ok %0d, checksum %0d, too long %0d, bad length %0d",
             status_seen[scpd_pkg::ST_OK], status_seen[scpd_pkg::ST_CKSUM],
             status_seen[scpd_pkg::ST_TOO_LONG], status_seen[scpd_pkg::ST_BAD_LEN]);
    if (errors == 0) begin
      $display("sum_checked_packet_deframer: match");
    end else begin
      $display("%0d mismatches", errors);
      $display("sum_checked_packet_deframer: mismatch");
    end
    $finish;
  end

endmodule
